// ===== rtl/core/afk_pkg.sv =====
`default_nettype none

package afk_pkg;

   // Fixed sizes of the transaction fields.
   localparam int JOINT_COUNT = 7;
   localparam int ANGLE_W = 16;
   localparam int FIELD_W = 20;
   localparam int FRAME_W = 3;
   localparam int ROW_W = 2;
   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam int OUT_FRAC_BITS_DEF = 16;

   // Internal arithmetic: signed Q30 with headroom, full-width products.
   localparam int WORK_FRAC = 30;
   localparam int WORK_W = 34;
   localparam int PROD_W = 2 * WORK_W;
   localparam int RECIP_SHIFT = 32;
   localparam int DIV_W = 8;
   localparam logic signed [WORK_W-1:0] ONE_Q30 = WORK_W'(64'sd1073741824);
   localparam int HALF_PI_Q30 = 1686629713;
   localparam int QUARTER_PI_Q30 = HALF_PI_Q30 / 2;
   localparam int FIELD_MAX = 524287;
   localparam int FIELD_MIN = -524288;

   // Depth of the angle-set queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Series terms: five for the sine, then six for the cosine.
   localparam int TERM_W = 4;
   localparam logic [TERM_W-1:0] TERM_SIN_LAST = 4'd4;
   localparam logic [TERM_W-1:0] TERM_COS_LAST = 4'd10;

   // Products used to compose one row of a frame.
   localparam int SEL_W = 3;
   localparam logic [SEL_W-1:0] SEL_R0_COS = 3'd0;
   localparam logic [SEL_W-1:0] SEL_R1_SIN = 3'd1;
   localparam logic [SEL_W-1:0] SEL_R0_SIN = 3'd2;
   localparam logic [SEL_W-1:0] SEL_R1_COS = 3'd3;
   localparam logic [SEL_W-1:0] SEL_OFFSET = 3'd4;

   localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;
   localparam logic [FRAME_W-1:0] FRAME_LAST = 3'd7;

   typedef enum logic [1:0] {
      TWIST_NONE,
      TWIST_POS,
      TWIST_NEG
   } twist_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_j1;
      logic signed [ANGLE_W-1:0] angle_j2;
      logic signed [ANGLE_W-1:0] angle_j3;
      logic signed [ANGLE_W-1:0] angle_j4;
      logic signed [ANGLE_W-1:0] angle_j5;
      logic signed [ANGLE_W-1:0] angle_j6;
      logic signed [ANGLE_W-1:0] angle_j7;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0]        frame_index;
      logic [ROW_W-1:0]          row_index;
      logic signed [FIELD_W-1:0] rotation_col0;
      logic signed [FIELD_W-1:0] rotation_col1;
      logic signed [FIELD_W-1:0] rotation_col2;
      logic signed [FIELD_W-1:0] translation;
      logic                      last_row;
   } rsp_type;

   typedef struct packed {
      logic signed [WORK_W-1:0] a;
      logic signed [WORK_W-1:0] b;
   } mul_op_type;

   // Round a full product back to Q30, half away from zero.
   function automatic logic signed [WORK_W-1:0] round_q30(logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      logic [WORK_W-1:0] r_w;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r = (mag + (PROD_W'(1) << (WORK_FRAC - 1))) >> WORK_FRAC;
      r_w = r[WORK_W-1:0];
      return p[PROD_W-1] ? -signed'(r_w) : signed'(r_w);
   endfunction

   // Divisor of each series term.
   function automatic logic [DIV_W-1:0] term_divisor(logic [TERM_W-1:0] idx);
      logic [DIV_W-1:0] d;
      unique case (idx)
         4'd0:    d = 8'd110;
         4'd1:    d = 8'd72;
         4'd2:    d = 8'd42;
         4'd3:    d = 8'd20;
         4'd4:    d = 8'd6;
         4'd5:    d = 8'd132;
         4'd6:    d = 8'd90;
         4'd7:    d = 8'd56;
         4'd8:    d = 8'd30;
         4'd9:    d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // Reciprocal of each divisor, floor(2^32 / d).
   function automatic logic [RECIP_SHIFT-1:0] term_recip(logic [TERM_W-1:0] idx);
      logic [RECIP_SHIFT-1:0] m;
      unique case (idx)
         4'd0:    m = 32'd39045157;
         4'd1:    m = 32'd59652323;
         4'd2:    m = 32'd102261126;
         4'd3:    m = 32'd214748364;
         4'd4:    m = 32'd715827882;
         4'd5:    m = 32'd32537631;
         4'd6:    m = 32'd47721858;
         4'd7:    m = 32'd76695844;
         4'd8:    m = 32'd143165576;
         4'd9:    m = 32'd357913941;
         default: m = 32'd2147483648;
      endcase
      return m;
   endfunction

   // Link offset along z of each joint, Q30 meters.
   function automatic logic signed [WORK_W-1:0] link_offset(logic [FRAME_W-1:0] j);
      logic signed [WORK_W-1:0] d;
      unique case (j)
         3'd0:    d = WORK_W'(64'sd332859965);
         3'd2:    d = WORK_W'(64'sd429496730);
         3'd4:    d = WORK_W'(64'sd418759311);
         3'd6:    d = WORK_W'(64'sd83751862);
         default: d = '0;
      endcase
      return d;
   endfunction

   // Twist of each joint: plus or minus a quarter turn, or none.
   function automatic twist_type twist_of(logic [FRAME_W-1:0] j);
      twist_type t;
      unique case (j)
         3'd0, 3'd3, 3'd4: t = TWIST_POS;
         3'd1, 3'd2, 3'd5: t = TWIST_NEG;
         default:          t = TWIST_NONE;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/afk_queue.sv =====
`default_nettype none

module afk_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_stall,
   input  wire afk_pkg::req_type push_data,
   output logic                  head_valid,
   output afk_pkg::req_type      head_data,
   input  wire logic             head_pop
);
   import afk_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   logic              pop;

   // Full queue holds off the sender; stall does not look at valid.
   assign push_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push = push_valid && !push_stall;
   assign pop = head_pop && head_valid;
   assign head_valid = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   // Storage for the queued angle sets.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/afk_mul.sv =====
`default_nettype none

module afk_mul (
   input  wire logic                             clock,
   input  wire afk_pkg::mul_op_type              mul_op,
   output logic signed [afk_pkg::PROD_W-1:0]     prod_ff
);
   import afk_pkg::*;

   // Shared signed multiplier with its product registered.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_op.a) * PROD_W'(mul_op.b);
   end

endmodule

`default_nettype wire

// ===== rtl/core/afk_engine.sv =====
`default_nettype none

module afk_engine #(
   parameter int ANGLE_FRAC_BITS = afk_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = afk_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire afk_pkg::req_type head_data,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output afk_pkg::rsp_type      rsp_data
);
   import afk_pkg::*;

   localparam int IN_SHIFT = WORK_FRAC - ANGLE_FRAC_BITS;
   localparam int X_W = ANGLE_W + IN_SHIFT + 1;
   localparam int OUT_SHIFT = WORK_FRAC - OUT_FRAC_BITS;
   localparam int REM_W = WORK_W + DIV_W + 1;
   localparam logic signed [X_W-1:0] HALF_PI_X = X_W'(HALF_PI_Q30);
   localparam logic signed [X_W-1:0] QUARTER_PI_X = X_W'(QUARTER_PI_Q30);
   localparam logic signed [WORK_W:0] FIELD_MAX_X = (WORK_W + 1)'(FIELD_MAX);
   localparam logic signed [WORK_W:0] FIELD_MIN_X = (WORK_W + 1)'(FIELD_MIN);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_LOAD,
      ST_REDUCE,
      ST_SQ,
      ST_SQ_DONE,
      ST_TERM_MUL,
      ST_TERM_DIV,
      ST_TERM_FIX,
      ST_SIN_MUL,
      ST_SIN_DONE,
      ST_ROW_MUL,
      ST_ROW_ACC
   } state_type;

   state_type                 state_ff;
   logic [FRAME_W-1:0]        frame_ff;
   logic [ROW_W-1:0]          row_ff;
   logic [TERM_W-1:0]         term_ff;
   logic [SEL_W-1:0]          sel_ff;
   logic [1:0]                quad_ff;
   logic signed [X_W-1:0]     x_ff;
   logic signed [WORK_W-1:0]  r2_ff;
   logic signed [WORK_W-1:0]  t_ff;
   logic signed [WORK_W-1:0]  ts_ff;
   logic signed [WORK_W-1:0]  n_ff;
   logic signed [WORK_W-1:0]  sin_ff;
   logic signed [WORK_W-1:0]  cos_ff;
   logic signed [WORK_W-1:0]  acc0_ff;
   logic signed [WORK_W-1:0]  acc2_ff;
   logic signed [WORK_W-1:0]  rot_ff [3][3];
   logic signed [WORK_W-1:0]  pos_ff [3];
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   logic signed [PROD_W-1:0]  prod_ff;
   mul_op_type                mul_op;
   logic signed [ANGLE_W-1:0] angle_sel;
   logic signed [X_W-1:0]     x_load_in;
   logic signed [WORK_W-1:0]  x_work;
   logic signed [WORK_W-1:0]  prod_rnd;
   logic [DIV_W-1:0]          div_d;
   logic signed [WORK_W-1:0]  n_in;
   logic [WORK_W-1:0]         quot_est;
   logic [REM_W-1:0]          rem_val;
   logic [WORK_W-1:0]         quot;
   logic signed [WORK_W-1:0]  t_in;
   logic signed [WORK_W-1:0]  sin_in;
   logic signed [WORK_W-1:0]  cos_in;
   logic                      out_free;
   twist_type                 twist;

   // Round a Q30 value to the output format and saturate to the field.
   function automatic logic signed [FIELD_W-1:0] to_field(logic signed [WORK_W-1:0] v);
      logic [WORK_W-1:0]     mag;
      logic [WORK_W-1:0]     r;
      logic signed [WORK_W:0] o;
      mag = v[WORK_W-1] ? WORK_W'(-v) : WORK_W'(v);
      r = (mag + (WORK_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      o = v[WORK_W-1] ? -signed'({1'b0, r}) : signed'({1'b0, r});
      if (o > FIELD_MAX_X) begin
         o = FIELD_MAX_X;
      end else if (o < FIELD_MIN_X) begin
         o = FIELD_MIN_X;
      end
      return o[FIELD_W-1:0];
   endfunction

   afk_mul u_mul (
      .clock   (clock),
      .mul_op  (mul_op),
      .prod_ff (prod_ff)
   );

   // Angle of the joint now being worked on, taken to the reduction format.
   always_comb begin
      case (frame_ff)
         3'd0:    angle_sel = head_data.angle_j1;
         3'd1:    angle_sel = head_data.angle_j2;
         3'd2:    angle_sel = head_data.angle_j3;
         3'd3:    angle_sel = head_data.angle_j4;
         3'd4:    angle_sel = head_data.angle_j5;
         3'd5:    angle_sel = head_data.angle_j6;
         default: angle_sel = head_data.angle_j7;
      endcase
   end

   assign x_load_in = X_W'(angle_sel) <<< IN_SHIFT;
   assign x_work = WORK_W'(x_ff);
   assign prod_rnd = round_q30(prod_ff);
   assign twist = twist_of(frame_ff);

   // Rounded division of a series term by a small constant: reciprocal
   // estimate, then one correction step on the remainder.
   assign div_d = term_divisor(term_ff);
   assign n_in = prod_rnd + WORK_W'(div_d >> 1);
   assign quot_est = prod_ff[RECIP_SHIFT +: WORK_W];
   assign rem_val = REM_W'(unsigned'(n_ff)) - (REM_W'(quot_est) * REM_W'(div_d));
   assign quot = (rem_val >= REM_W'(div_d)) ? quot_est + 1'b1 : quot_est;
   assign t_in = ONE_Q30 - signed'(quot);

   // Fold the quadrant back into the sine and cosine of the reduced angle.
   always_comb begin
      case (quad_ff)
         2'd0: begin
            sin_in = prod_rnd;
            cos_in = t_ff;
         end
         2'd1: begin
            sin_in = t_ff;
            cos_in = -prod_rnd;
         end
         2'd2: begin
            sin_in = -prod_rnd;
            cos_in = -t_ff;
         end
         default: begin
            sin_in = -t_ff;
            cos_in = prod_rnd;
         end
      endcase
   end

   // Operands of the shared multiplier for each step.
   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      case (state_ff)
         ST_SQ: begin
            mul_op.a = x_work;
            mul_op.b = x_work;
         end
         ST_TERM_MUL: begin
            mul_op.a = r2_ff;
            mul_op.b = t_ff;
         end
         ST_TERM_DIV: begin
            mul_op.a = n_in;
            mul_op.b = signed'(WORK_W'(term_recip(term_ff)));
         end
         ST_SIN_MUL: begin
            mul_op.a = x_work;
            mul_op.b = ts_ff;
         end
         ST_ROW_MUL: begin
            case (sel_ff)
               SEL_R0_COS: begin
                  mul_op.a = rot_ff[row_ff][0];
                  mul_op.b = cos_ff;
               end
               SEL_R1_SIN: begin
                  mul_op.a = rot_ff[row_ff][1];
                  mul_op.b = sin_ff;
               end
               SEL_R0_SIN: begin
                  mul_op.a = rot_ff[row_ff][0];
                  mul_op.b = sin_ff;
               end
               SEL_R1_COS: begin
                  mul_op.a = rot_ff[row_ff][1];
                  mul_op.b = cos_ff;
               end
               default: begin
                  mul_op.a = rot_ff[row_ff][2];
                  mul_op.b = link_offset(frame_ff);
               end
            endcase
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign head_pop = (state_ff == ST_EMIT) && out_free && (row_ff == ROW_LAST)
                     && (frame_ff == FRAME_LAST);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Sequencer: emit a frame, then build the next joint's sine and cosine
   // and compose it into the running frame one row at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         frame_ff <= '0;
         row_ff <= '0;
         term_ff <= '0;
         sel_ff <= '0;
         quad_ff <= '0;
      end else begin
         // While emitting, the output register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  for (int i = 0; i < 3; i++) begin
                     pos_ff[i] <= '0;
                     for (int j = 0; j < 3; j++) begin
                        rot_ff[i][j] <= (i == j) ? ONE_Q30 : '0;
                     end
                  end
                  frame_ff <= '0;
                  row_ff <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.frame_index <= frame_ff;
                  rsp_data_ff.row_index <= row_ff;
                  rsp_data_ff.rotation_col0 <= to_field(rot_ff[row_ff][0]);
                  rsp_data_ff.rotation_col1 <= to_field(rot_ff[row_ff][1]);
                  rsp_data_ff.rotation_col2 <= to_field(rot_ff[row_ff][2]);
                  rsp_data_ff.translation <= to_field(pos_ff[row_ff]);
                  rsp_data_ff.last_row <= (frame_ff == FRAME_LAST) && (row_ff == ROW_LAST);
                  if (row_ff == ROW_LAST) begin
                     row_ff <= '0;
                     state_ff <= (frame_ff == FRAME_LAST) ? ST_IDLE : ST_LOAD;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end
            end
            ST_LOAD: begin
               x_ff <= x_load_in;
               quad_ff <= '0;
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               if (x_ff > QUARTER_PI_X) begin
                  x_ff <= x_ff - HALF_PI_X;
                  quad_ff <= quad_ff + 1'b1;
               end else if (x_ff < -QUARTER_PI_X) begin
                  x_ff <= x_ff + HALF_PI_X;
                  quad_ff <= quad_ff - 1'b1;
               end else begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               state_ff <= ST_SQ_DONE;
            end
            ST_SQ_DONE: begin
               r2_ff <= prod_rnd;
               t_ff <= ONE_Q30;
               term_ff <= '0;
               state_ff <= ST_TERM_MUL;
            end
            ST_TERM_MUL: begin
               state_ff <= ST_TERM_DIV;
            end
            ST_TERM_DIV: begin
               n_ff <= n_in;
               state_ff <= ST_TERM_FIX;
            end
            ST_TERM_FIX: begin
               term_ff <= term_ff + 1'b1;
               if (term_ff == TERM_SIN_LAST) begin
                  ts_ff <= t_in;
                  t_ff <= ONE_Q30;
                  state_ff <= ST_TERM_MUL;
               end else if (term_ff == TERM_COS_LAST) begin
                  t_ff <= t_in;
                  state_ff <= ST_SIN_MUL;
               end else begin
                  t_ff <= t_in;
                  state_ff <= ST_TERM_MUL;
               end
            end
            ST_SIN_MUL: begin
               state_ff <= ST_SIN_DONE;
            end
            ST_SIN_DONE: begin
               sin_ff <= sin_in;
               cos_ff <= cos_in;
               row_ff <= '0;
               sel_ff <= '0;
               state_ff <= ST_ROW_MUL;
            end
            ST_ROW_MUL: begin
               state_ff <= ST_ROW_ACC;
            end
            ST_ROW_ACC: begin
               case (sel_ff)
                  SEL_R0_COS: acc0_ff <= prod_rnd;
                  SEL_R1_SIN: acc0_ff <= acc0_ff + prod_rnd;
                  SEL_R0_SIN: acc2_ff <= prod_rnd;
                  SEL_R1_COS: acc2_ff <= acc2_ff - prod_rnd;
                  default: begin
                     pos_ff[row_ff] <= pos_ff[row_ff] + prod_rnd;
                     rot_ff[row_ff][0] <= acc0_ff;
                     case (twist)
                        TWIST_POS: begin
                           rot_ff[row_ff][1] <= rot_ff[row_ff][2];
                           rot_ff[row_ff][2] <= acc2_ff;
                        end
                        TWIST_NEG: begin
                           rot_ff[row_ff][1] <= -rot_ff[row_ff][2];
                           rot_ff[row_ff][2] <= -acc2_ff;
                        end
                        default: begin
                           rot_ff[row_ff][1] <= -acc2_ff;
                        end
                     endcase
                  end
               endcase
               if (sel_ff == SEL_OFFSET) begin
                  sel_ff <= '0;
                  if (row_ff == ROW_LAST) begin
                     row_ff <= '0;
                     frame_ff <= frame_ff + 1'b1;
                     state_ff <= ST_EMIT;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                     state_ff <= ST_ROW_MUL;
                  end
               end else begin
                  sel_ff <= sel_ff + 1'b1;
                  state_ff <= ST_ROW_MUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/arm_forward_kinematics.sv =====
`default_nettype none

// Channel   Direction  Handshake           Transaction
// req_      in         req_valid/stall     seven joint angles
// rsp_      out        rsp_valid/stall     one row of one cumulative frame
//
// Each angle set gives 24 rows, frames 0 to 7, rows 0 to 2 in order.
// One set takes longer for each quarter turn removed from an angle; the single
// shared multiplier, used by the series steps and the row steps, sets its pace.
// A two-deep queue takes new sets while the back end works; req_stall rises
// only when it is full. rsp_stall holds the output register, and the sequencer when it has a row to emit.
// Reset is synchronous and clears the queue and the sequencer.

module arm_forward_kinematics #(
   parameter int ANGLE_FRAC_BITS = afk_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = afk_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire afk_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output afk_pkg::rsp_type      rsp_data
);
   import afk_pkg::*;

   logic    head_valid;
   req_type head_data;
   logic    head_pop;

   afk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_data  (req_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop)
   );

   afk_engine #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS   (OUT_FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // The last-row flag marks only row 2 of frame 7.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_row |->
         rsp_data.frame_index == FRAME_LAST && rsp_data.row_index == ROW_LAST)
      else $error("last_row on a row other than the final one");

   // The base frame has no translation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_index == '0 |-> rsp_data.translation == '0)
      else $error("base frame with nonzero translation");

   // A frame has three rows only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.row_index != 2'd3)
      else $error("row index out of range");

   // The queue is never popped while empty.
   assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("angle set consumed from an empty queue");

endmodule

`default_nettype wire
